// ===== rtl/fsrs_pkg.sv =====
// Package: shared types and constants of the frame separator row segmenter.
`timescale 1ns / 1ps
`default_nettype none
package fsrs_pkg;

	localparam int ROW_BITS = 12;
	localparam int SCAN_BITS = ROW_BITS + 1;
	localparam int STRAY_BITS = 13;
	localparam int RUN_BITS = 11;
	localparam int CFG_DATA_BITS = 13;
	localparam int CFG_INDEX_BITS = 3;
	localparam int INDEX_BITS = 5;
	localparam int FOUND_BITS = 6;
	localparam int TABLE_ENTRIES = 32;

	localparam logic [RUN_BITS-1:0] RUN_SAT = 11'd2047;

	// register defaults
	localparam logic        FRAME_MODE_RST     = 1'b1;
	localparam logic [11:0] IMAGE_HEIGHT_RST   = 12'd1024;
	localparam logic [9:0]  MIN_FRAME_ROWS_RST = 10'd32;
	localparam logic [9:0]  SEPARATOR_MAX_RST  = 10'd16;
	localparam logic [12:0] RANDOM_MAX_RST     = 13'd80;
	localparam logic [7:0]  WHITE_LEVEL_RST    = 8'd160;
	localparam logic [7:0]  BLACK_LEVEL_RST    = 8'd60;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FRAME_MODE     = 3'd0,
		REG_IMAGE_HEIGHT   = 3'd1,
		REG_MIN_FRAME_ROWS = 3'd2,
		REG_SEPARATOR_MAX  = 3'd3,
		REG_RANDOM_MAX     = 3'd4,
		REG_WHITE_LEVEL    = 3'd5,
		REG_BLACK_LEVEL    = 3'd6
	} reg_index_t;

	typedef enum logic [3:0] {
		PH_SCAN = 4'b0001,
		PH_RUN  = 4'b0010,
		PH_OK   = 4'b0100,
		PH_FAIL = 4'b1000
	} phase_t;

endpackage
`default_nettype wire

// ===== rtl/fsrs_if.sv =====
// Interfaces: pixel word channel and frame result word channel.
`timescale 1ns / 1ps
`default_nettype none
interface fsrs_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_level;
	logic [7:0] green_level;
	logic [7:0] blue_level;
	logic       row_end;
	logic       image_end;

	modport source (output valid, red_level, green_level, blue_level, row_end, image_end,
		input ready);
	modport sink (input valid, red_level, green_level, blue_level, row_end, image_end,
		output ready);
endinterface

interface fsrs_frm_if;
	logic                                valid;
	logic                                ready;
	logic [fsrs_pkg::INDEX_BITS-1:0]     frame_index;
	logic [fsrs_pkg::ROW_BITS-1:0]       frame_top;
	logic [fsrs_pkg::ROW_BITS-1:0]       frame_bottom;
	logic [fsrs_pkg::FOUND_BITS-1:0]     frames_found;
	logic                                table_overflow;
	logic                                run_last;

	modport source (output valid, frame_index, frame_top, frame_bottom, frames_found,
		table_overflow, run_last, input ready);
	modport sink (input valid, frame_index, frame_top, frame_bottom, frames_found,
		table_overflow, run_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/frame_separator_row_segmenter_unit.sv =====
// Top level: row separator search over a raster pixel stream and frame table readout.
`timescale 1ns / 1ps
`default_nettype none
// Pixels enter on the pixel channel one word per cycle while ready is high, and pass an
// input register before the per-pixel stray count and the row judgment update the search
// state in the following cycle. Rows are judged on the word that carries row_end or
// image_end; that word's color is ignored. On the image_end word the run of frame results
// is built: the input holds ready low until the last result of the run is loaded, as the
// frame tables have a separate write port and are read one entry per cycle, while the
// result side accepts, through a registered read port. Results leave through an output
// register, so a new image can start while the last result of a run waits. The frame tables
// are never cleared; only entries written during the current image are read. Configuration
// must be written only while no image is in progress; the block itself does not enforce it.
module frame_separator_row_segmenter_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	fsrs_pix_if.sink                                   pixel,
	fsrs_frm_if.source                                 frame,
	input  wire logic                                  cfg_write,
	input  wire logic [fsrs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [fsrs_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	localparam int IDX_W = $clog2(fsrs_pkg::TABLE_ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam int RB = fsrs_pkg::ROW_BITS;
	localparam int SB = fsrs_pkg::SCAN_BITS;
	localparam logic [CNT_W-1:0] ENTRIES = CNT_W'(fsrs_pkg::TABLE_ENTRIES);

	// configuration
	logic        frame_mode_q;
	logic [11:0] image_height_q;
	logic [9:0]  min_frame_rows_q;
	logic [9:0]  separator_max_q;
	logic [12:0] random_max_q;
	logic [7:0]  white_level_q;
	logic [7:0]  black_level_q;

	// input register
	logic       valid_s1;
	logic [7:0] red_s1, green_s1, blue_s1;
	logic       row_end_s1, image_end_s1;

	// search state
	logic [RB-1:0]                     row_counter_q;
	logic [SB-1:0]                     scan_row_q;
	logic [fsrs_pkg::STRAY_BITS-1:0]   stray_count_q;
	logic                              previous_white_q;
	logic                              row_failed_q;
	fsrs_pkg::phase_t                  phase_q;
	logic [fsrs_pkg::RUN_BITS-1:0]     separator_run_q;
	logic [IDX_W-1:0]                  frame_counter_q;
	logic                              overflow_q;

	// run readout
	logic                              emit_busy_q;
	logic                              emit_data_ok_q;
	logic                              emit_ok_q;
	logic [IDX_W-1:0]                  emit_k_q;
	logic [CNT_W-1:0]                  emit_count_q;
	logic [11:0]                       emit_alt_bottom_q;
	logic [fsrs_pkg::FOUND_BITS-1:0]   emit_found_q;
	logic                              emit_ovf_q;

	// frame tables
	logic [11:0] top_mem [fsrs_pkg::TABLE_ENTRIES];
	logic [11:0] bottom_mem [fsrs_pkg::TABLE_ENTRIES];
	logic [11:0] rd_top_q, rd_bottom_q;
	logic [IDX_W-1:0] rd_addr;

	// output register
	logic                              out_valid_q;
	logic [fsrs_pkg::INDEX_BITS-1:0]   out_index_q;
	logic [11:0]                       out_top_q, out_bottom_q;
	logic [fsrs_pkg::FOUND_BITS-1:0]   out_found_q;
	logic                              out_ovf_q, out_last_q;

	// ---------------------------------------------------------------- pixel path
	logic                              pix_acc;
	logic                              is_black, is_white;
	logic [fsrs_pkg::STRAY_BITS:0]     stray_sum;
	logic                              stray_over;
	logic                              row_step;

	assign pixel.ready = !emit_busy_q && !(valid_s1 && image_end_s1);
	assign pix_acc = pixel.valid && pixel.ready;
	assign row_step = valid_s1 && (row_end_s1 || image_end_s1);

	always_comb begin
		is_black = (red_s1 < black_level_q) && (green_s1 < black_level_q) &&
			(blue_s1 < black_level_q);
		is_white = (red_s1 > white_level_q) && (green_s1 > white_level_q) &&
			(blue_s1 > white_level_q);
		stray_sum = {1'b0, stray_count_q}
			+ (fsrs_pkg::STRAY_BITS+1)'((red_s1 != green_s1) || (red_s1 != blue_s1))
			+ (fsrs_pkg::STRAY_BITS+1)'(previous_white_q && is_black)
			+ (fsrs_pkg::STRAY_BITS+1)'(!previous_white_q && is_white);
		stray_over = stray_sum > {1'b0, random_max_q};
	end

	// ---------------------------------------------------------------- row judgment
	logic                              judge;
	logic                              sep;
	logic signed [14:0]                h_minus_f;
	logic signed [14:0]                vp_s, vp_addf_s;
	logic [SB:0]                       vp_inc, vp_addf;
	logic [fsrs_pkg::RUN_BITS-1:0]     run_inc;
	logic                              fc_room;

	fsrs_pkg::phase_t                  phase_d;
	logic [SB-1:0]                     scan_row_d;
	logic [fsrs_pkg::RUN_BITS-1:0]     run_d;
	logic [IDX_W-1:0]                  fc_d;
	logic                              ovf_d;
	logic                              top_we, bottom_we;
	logic [11:0]                       top_wdata, bottom_wdata;

	always_comb begin
		judge = row_step && (phase_q == fsrs_pkg::PH_SCAN || phase_q == fsrs_pkg::PH_RUN)
			&& ({1'b0, row_counter_q} == scan_row_q);
		sep = !row_failed_q;
		h_minus_f = $signed({3'b000, image_height_q}) - $signed({5'b00000, min_frame_rows_q});
		vp_inc = {1'b0, scan_row_q} + (SB+1)'(1);
		vp_addf = {1'b0, scan_row_q} + (SB+1)'(min_frame_rows_q);
		vp_s = $signed(15'(scan_row_q));
		vp_addf_s = $signed(15'(vp_addf));
		run_inc = (separator_run_q < fsrs_pkg::RUN_SAT) ? separator_run_q + 1'b1
			: separator_run_q;
		fc_room = ({1'b0, frame_counter_q} + CNT_W'(1)) < ENTRIES;

		phase_d = phase_q;
		scan_row_d = scan_row_q;
		run_d = separator_run_q;
		fc_d = frame_counter_q;
		ovf_d = overflow_q;
		top_we = 1'b0;
		bottom_we = 1'b0;
		top_wdata = scan_row_q[11:0];
		bottom_wdata = scan_row_q[11:0];

		if (judge) begin
			unique case (phase_q)
				fsrs_pkg::PH_SCAN: begin
					if (sep && fc_room) begin
						bottom_we = 1'b1;
						scan_row_d = vp_inc[SB-1:0];
						run_d = fsrs_pkg::RUN_BITS'(1);
						fc_d = frame_counter_q + 1'b1;
						phase_d = fsrs_pkg::PH_RUN;
					end else begin
						if (sep)
							ovf_d = 1'b1;
						if (h_minus_f > vp_s) begin
							scan_row_d = vp_inc[SB-1:0];
						end else if (frame_counter_q != '0) begin
							bottom_we = 1'b1;
							bottom_wdata = image_height_q;
							phase_d = fsrs_pkg::PH_OK;
						end else begin
							phase_d = fsrs_pkg::PH_FAIL;
						end
					end
				end
				fsrs_pkg::PH_RUN: begin
					if (sep) begin
						run_d = run_inc;
						if (h_minus_f < vp_s || run_inc > {1'b0, separator_max_q}) begin
							if (frame_counter_q > IDX_W'(1)) begin
								top_we = 1'b1;
								bottom_we = 1'b1;
								bottom_wdata = image_height_q;
								phase_d = fsrs_pkg::PH_OK;
							end else begin
								phase_d = fsrs_pkg::PH_FAIL;
							end
						end else begin
							scan_row_d = vp_inc[SB-1:0];
						end
					end else begin
						run_d = '0;
						top_we = 1'b1;
						scan_row_d = vp_addf[SB-1:0];
						if (h_minus_f > vp_addf_s) begin
							phase_d = fsrs_pkg::PH_SCAN;
						end else begin
							bottom_we = 1'b1;
							bottom_wdata = image_height_q;
							phase_d = fsrs_pkg::PH_OK;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- readout control
	logic             run_start;
	logic             out_load;
	logic             k_last;

	assign run_start = valid_s1 && image_end_s1;
	assign out_load = emit_busy_q && emit_data_ok_q && (!out_valid_q || frame.ready);
	assign k_last = ({1'b0, emit_k_q} + CNT_W'(1)) == emit_count_q;
	assign rd_addr = out_load ? emit_k_q + 1'b1 : emit_k_q;

	always_ff @(posedge clk) begin
		if (top_we)
			top_mem[frame_counter_q] <= top_wdata;
		if (bottom_we)
			bottom_mem[frame_counter_q] <= bottom_wdata;
		rd_top_q <= top_mem[rd_addr];
		rd_bottom_q <= bottom_mem[rd_addr];
	end

	// ---------------------------------------------------------------- state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q <= fsrs_pkg::FRAME_MODE_RST;
			image_height_q <= fsrs_pkg::IMAGE_HEIGHT_RST;
			min_frame_rows_q <= fsrs_pkg::MIN_FRAME_ROWS_RST;
			separator_max_q <= fsrs_pkg::SEPARATOR_MAX_RST;
			random_max_q <= fsrs_pkg::RANDOM_MAX_RST;
			white_level_q <= fsrs_pkg::WHITE_LEVEL_RST;
			black_level_q <= fsrs_pkg::BLACK_LEVEL_RST;
			valid_s1 <= 1'b0;
			row_counter_q <= '0;
			scan_row_q <= SB'(fsrs_pkg::MIN_FRAME_ROWS_RST);
			stray_count_q <= '0;
			previous_white_q <= 1'b1;
			row_failed_q <= 1'b0;
			phase_q <= fsrs_pkg::PH_SCAN;
			separator_run_q <= '0;
			frame_counter_q <= '0;
			overflow_q <= 1'b0;
			emit_busy_q <= 1'b0;
			emit_data_ok_q <= 1'b0;
			emit_k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= pix_acc;

			if (valid_s1 && !row_step && !row_failed_q) begin
				if (stray_over) begin
					row_failed_q <= 1'b1;
				end else begin
					stray_count_q <= stray_sum[fsrs_pkg::STRAY_BITS-1:0];
					if (is_white)
						previous_white_q <= 1'b1;
					if (is_black)
						previous_white_q <= 1'b0;
				end
			end

			if (row_step) begin
				stray_count_q <= '0;
				previous_white_q <= 1'b1;
				row_failed_q <= 1'b0;
				if (image_end_s1) begin
					row_counter_q <= '0;
					scan_row_q <= SB'(min_frame_rows_q);
					phase_q <= fsrs_pkg::PH_SCAN;
					separator_run_q <= '0;
					frame_counter_q <= '0;
					overflow_q <= 1'b0;
				end else begin
					row_counter_q <= row_counter_q + 1'b1;
					scan_row_q <= scan_row_d;
					phase_q <= phase_d;
					separator_run_q <= run_d;
					frame_counter_q <= fc_d;
					overflow_q <= ovf_d;
				end
			end

			// run readout: table words arrive in the cycle after their address
			if (run_start) begin
				emit_busy_q <= 1'b1;
				emit_k_q <= '0;
			end else if (out_load) begin
				emit_k_q <= emit_k_q + 1'b1;
				if (k_last)
					emit_busy_q <= 1'b0;
			end
			emit_data_ok_q <= emit_busy_q && !run_start;

			if (out_load)
				out_valid_q <= 1'b1;
			else if (frame.ready)
				out_valid_q <= 1'b0;

			if (cfg_write) begin
				unique case (cfg_index)
					fsrs_pkg::REG_FRAME_MODE:    frame_mode_q <= cfg_data[0];
					fsrs_pkg::REG_IMAGE_HEIGHT:  image_height_q <= cfg_data[11:0];
					fsrs_pkg::REG_MIN_FRAME_ROWS: begin
						min_frame_rows_q <= cfg_data[9:0];
						if (row_counter_q == '0)
							scan_row_q <= SB'(cfg_data[9:0]);
					end
					fsrs_pkg::REG_SEPARATOR_MAX: separator_max_q <= cfg_data[9:0];
					fsrs_pkg::REG_RANDOM_MAX:    random_max_q <= cfg_data[12:0];
					fsrs_pkg::REG_WHITE_LEVEL:   white_level_q <= cfg_data[7:0];
					fsrs_pkg::REG_BLACK_LEVEL:   black_level_q <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
		end
	end

	// input word and run descriptor registers, no reset needed
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			red_s1 <= pixel.red_level;
			green_s1 <= pixel.green_level;
			blue_s1 <= pixel.blue_level;
			row_end_s1 <= pixel.row_end;
			image_end_s1 <= pixel.image_end;
		end
		if (run_start) begin
			emit_ovf_q <= ovf_d;
			if (!frame_mode_q) begin
				emit_ok_q <= 1'b0;
				emit_count_q <= CNT_W'(1);
				emit_alt_bottom_q <= image_height_q - 12'd1;
				emit_found_q <= '0;
			end else if (phase_d == fsrs_pkg::PH_OK) begin
				emit_ok_q <= 1'b1;
				emit_count_q <= {1'b0, fc_d} + CNT_W'(1);
				emit_alt_bottom_q <= '0;
				emit_found_q <= fsrs_pkg::FOUND_BITS'({1'b0, fc_d} + CNT_W'(1));
			end else begin
				emit_ok_q <= 1'b0;
				emit_count_q <= CNT_W'(1);
				emit_alt_bottom_q <= '0;
				emit_found_q <= '0;
			end
		end
		if (out_load) begin
			out_index_q <= fsrs_pkg::INDEX_BITS'(emit_k_q);
			out_top_q <= (emit_ok_q && emit_k_q != '0) ? rd_top_q : 12'd0;
			out_bottom_q <= emit_ok_q ? rd_bottom_q : emit_alt_bottom_q;
			out_found_q <= emit_found_q;
			out_ovf_q <= emit_ovf_q;
			out_last_q <= k_last;
		end
	end

	assign frame.valid = out_valid_q;
	assign frame.frame_index = out_index_q;
	assign frame.frame_top = out_top_q;
	assign frame.frame_bottom = out_bottom_q;
	assign frame.frames_found = out_found_q;
	assign frame.table_overflow = out_ovf_q;
	assign frame.run_last = out_last_q;

	// ---------------------------------------------------------------- assertions
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && k_last |=> !emit_busy_q)
		else $error("readout still busy after last word of the run");

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		emit_busy_q && !run_start |-> ({1'b0, emit_k_q} < emit_count_q))
		else $error("readout index past frame count");

	a_index_below_found: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.frames_found != '0 |->
			(fsrs_pkg::FOUND_BITS'(frame.frame_index) < frame.frames_found))
		else $error("frame index not below frames found");

	a_no_pixel_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		run_start |=> !pixel.ready)
		else $error("pixel channel open while run is read out");

endmodule
`default_nettype wire
